[rtl/cnw_pkg.sv]
// ----------------------------------------------------------------------------
// cnw_pkg
// Shared types and constants for the character LCD nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package cnw_pkg;

  // item codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_CMD    = 2'd1;
  localparam logic [1:0] FUNC_CHAR   = 2'd2;
  localparam logic [1:0] FUNC_CURSOR = 2'd3;

  // controller commands
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  // register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT  = 2'd2;

  localparam logic [7:0]  PULSE_RST      = 8'd1;
  localparam logic [15:0] SHORT_WAIT_RST = 16'd40;
  localparam logic [15:0] LONG_WAIT_RST  = 16'd2000;

  typedef struct packed {
    logic [7:0]  enable_pulse_ticks;
    logic [15:0] short_wait_ticks;
    logic [15:0] long_wait_ticks;
  } cnw_cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] value;
    logic [5:0] column;
    logic       row;
  } cnw_item_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       rs_line;
    logic       en_line;
    logic       busy_res;
    logic       accepted;
  } cnw_result_t;

endpackage

`default_nettype wire

[rtl/cnw_ifs.sv]
// ----------------------------------------------------------------------------
// cnw channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] value;
  logic [5:0] column;
  logic       row;

  modport source (output valid, func, value, column, row, input ready);
  modport sink   (input valid, func, value, column, row, output ready);
endinterface

interface cnw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       rs_line;
  logic       en_line;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, data_nibble, rs_line, en_line, busy_res, accepted,
                  input ready);
  modport sink   (input valid, data_nibble, rs_line, en_line, busy_res, accepted,
                  output ready);
endinterface

interface cnw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cnw_pkg::CFG_IDX_W-1:0]  index;
  logic [cnw_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/cnw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cnw_cfg_regs
// Timing registers: enable pulse length, short and long wait.
// ----------------------------------------------------------------------------
`default_nettype none

module cnw_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [cnw_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [cnw_pkg::CFG_DAT_W-1:0] wr_data,
  output cnw_pkg::cnw_cfg_t                  cfg
);

  cnw_pkg::cnw_cfg_t cfg_r;
  cnw_pkg::cnw_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        cnw_pkg::REG_PULSE:      cfg_nxt.enable_pulse_ticks = wr_data[7:0];
        cnw_pkg::REG_SHORT_WAIT: cfg_nxt.short_wait_ticks   = wr_data;
        cnw_pkg::REG_LONG_WAIT:  cfg_nxt.long_wait_ticks    = wr_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_ticks <= cnw_pkg::PULSE_RST;
      cfg_r.short_wait_ticks   <= cnw_pkg::SHORT_WAIT_RST;
      cfg_r.long_wait_ticks    <= cnw_pkg::LONG_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/cnw_seq.sv]
// ----------------------------------------------------------------------------
// cnw_seq
// Nibble sequencer: phase, held byte and tick counter, one step per item.
// ----------------------------------------------------------------------------
`default_nettype none

module cnw_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire cnw_pkg::cnw_item_t  item,
  input  wire cnw_pkg::cnw_cfg_t   cfg,
  output cnw_pkg::cnw_result_t     res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SETUP_HI = 3'd1;
  localparam logic [2:0] PH_PULSE_HI = 3'd2;
  localparam logic [2:0] PH_GAP      = 3'd3;
  localparam logic [2:0] PH_SETUP_LO = 3'd4;
  localparam logic [2:0] PH_PULSE_LO = 3'd5;
  localparam logic [2:0] PH_WAIT     = 3'd6;

  logic [2:0]  phase_r,     phase_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_rs_r,   held_rs_nxt;
  logic        long_r,      long_nxt;
  logic [15:0] tick_r,      tick_nxt;

  logic [15:0] cnt_inc;
  logic [15:0] limit;
  logic        done;
  logic [6:0]  addr;

  assign cnt_inc = tick_r + 16'd1;
  // one compare serves both the enable pulse and the post-byte wait
  assign limit = (phase_r == PH_WAIT) ?
                 (long_r ? cfg.long_wait_ticks : cfg.short_wait_ticks) :
                 {8'd0, cfg.enable_pulse_ticks};
  assign done  = (cnt_inc >= limit);
  assign addr  = {1'b0, item.column} + {item.row, 6'd0};

  always_comb begin
    phase_nxt     = phase_r;
    held_byte_nxt = held_byte_r;
    held_rs_nxt   = held_rs_r;
    long_nxt      = long_r;
    tick_nxt      = tick_r;
    res           = '0;

    if (item.func == cnw_pkg::FUNC_TICK) begin
      case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_SETUP_HI: begin
          phase_nxt = PH_PULSE_HI;
          tick_nxt  = '0;
        end
        PH_PULSE_HI: begin
          if (done) begin
            phase_nxt = PH_GAP;
            tick_nxt  = '0;
          end else begin
            tick_nxt = cnt_inc;
          end
        end
        PH_GAP: phase_nxt = PH_SETUP_LO;
        PH_SETUP_LO: begin
          phase_nxt = PH_PULSE_LO;
          tick_nxt  = '0;
        end
        PH_PULSE_LO: begin
          if (done) begin
            phase_nxt = PH_WAIT;
            tick_nxt  = '0;
          end else begin
            tick_nxt = cnt_inc;
          end
        end
        PH_WAIT: begin
          if (done) begin
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
          end else begin
            tick_nxt = cnt_inc;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (phase_r == PH_IDLE) begin
      res.accepted = 1'b1;
      if (item.func == cnw_pkg::FUNC_CURSOR) begin
        held_byte_nxt = {1'b1, addr};
        held_rs_nxt   = 1'b0;
        long_nxt      = 1'b0;
      end else begin
        held_byte_nxt = item.value;
        held_rs_nxt   = (item.func == cnw_pkg::FUNC_CHAR);
        long_nxt      = (item.func == cnw_pkg::FUNC_CMD) &&
                        ((item.value == cnw_pkg::CMD_CLEAR) ||
                         (item.value == cnw_pkg::CMD_HOME));
      end
      tick_nxt  = '0;
      phase_nxt = PH_SETUP_HI;
    end

    // line levels after the step
    case (phase_nxt)
      PH_SETUP_HI: begin
        res.data_nibble = held_byte_nxt[7:4];
        res.rs_line     = held_rs_nxt;
      end
      PH_PULSE_HI: begin
        res.data_nibble = held_byte_nxt[7:4];
        res.rs_line     = held_rs_nxt;
        res.en_line     = 1'b1;
      end
      PH_SETUP_LO: begin
        res.data_nibble = held_byte_nxt[3:0];
        res.rs_line     = held_rs_nxt;
      end
      PH_PULSE_LO: begin
        res.data_nibble = held_byte_nxt[3:0];
        res.rs_line     = held_rs_nxt;
        res.en_line     = 1'b1;
      end
      default: res.data_nibble = 4'd0;
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_byte_r <= '0;
      held_rs_r   <= 1'b0;
      long_r      <= 1'b0;
      tick_r      <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      held_byte_r <= held_byte_nxt;
      held_rs_r   <= held_rs_nxt;
      long_r      <= long_nxt;
      tick_r      <= tick_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_writer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Drives a character LCD over a 4-bit bus, one item per clock while results are taken.
// ----------------------------------------------------------------------------
//
//  channel  direction  carries                                       handshake
//  in_ch    in         func, value, column, row                      valid/ready
//  out_ch   out        data_nibble, rs_line, en_line, busy_res,      valid/ready
//                      accepted
//  cfg_ch   in         index, data (pulse, short wait, long wait)    valid/ready
//
//  one item per clock sustained while out_ch is ready; each item gives exactly one result
//  each item passes the input register, then the sequencer step into the result register
//  reset (rst_n low, synchronous) clears the phase and counter and loads the timing registers with their defaults
//  a stalled result holds the result register; a full input register then holds
//  its item and in_ch.ready drops
//  register writes are always taken (cfg_ch.ready is tied high)
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cnw_in_if.sink     in_ch,
  cnw_out_if.source  out_ch,
  cnw_cfg_if.sink    cfg_ch
);

  cnw_pkg::cnw_cfg_t    cfg;
  cnw_pkg::cnw_item_t   s1_item_r;
  cnw_pkg::cnw_result_t res_nxt;
  cnw_pkg::cnw_result_t res_r;

  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic in_xfer;

  // register writes
  assign cfg_ch.ready = 1'b1;

  cnw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // result register is free or draining this cycle
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.func   <= in_ch.func;
      s1_item_r.value  <= in_ch.value;
      s1_item_r.column <= in_ch.column;
      s1_item_r.row    <= in_ch.row;
    end
  end

  // sequencer state moves only when its result enters the result register
  cnw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_valid_r && advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_nibble = res_r.data_nibble;
  assign out_ch.rs_line     = res_r.rs_line;
  assign out_ch.en_line     = res_r.en_line;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.accepted    = res_r.accepted;

endmodule

`default_nettype wire

[rtl/cnw_checker.sv]
// ----------------------------------------------------------------------------
// cnw_checker
// Port-level checks on the result channel of the nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

module cnw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] data_nibble,
  input wire logic       rs_line,
  input wire logic       en_line,
  input wire logic       busy_res,
  input wire logic       accepted
);

  // the strobe only rises inside a transfer
  a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && en_line |-> busy_res)
    else $error("enable high while not busy");

  // lines are released when idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> (data_nibble == 4'd0) && !rs_line && !en_line)
    else $error("lines driven while idle");

  // a taken write starts with setup: busy, strobe low
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |-> busy_res && !en_line)
    else $error("accepted write did not start with setup");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind char_lcd_nibble_writer cnw_checker u_cnw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .data_nibble (out_ch.data_nibble),
  .rs_line     (out_ch.rs_line),
  .en_line     (out_ch.en_line),
  .busy_res    (out_ch.busy_res),
  .accepted    (out_ch.accepted)
);

`default_nettype wire

[tb/char_lcd_nibble_writer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_tb
// Drives ticks, command bytes, character bytes and cursor moves into the LCD
// nibble writer under several timing setups, tracks the expected line levels
// with a cycle-free model of the nibble sequencer, and checks every result
// transfer against it while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module char_lcd_nibble_writer_tb;

  // sequencer phases of the line model
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_SETUP_HI = 4'd1;
  localparam logic [3:0] PH_PULSE_HI = 4'd2;
  localparam logic [3:0] PH_GAP      = 4'd3;
  localparam logic [3:0] PH_SETUP_LO = 4'd4;
  localparam logic [3:0] PH_PULSE_LO = 4'd5;
  localparam logic [3:0] PH_WAIT     = 4'd6;

  localparam logic [7:0] SET_ADDR_CMD   = 8'h80;
  localparam logic [7:0] ROW1_BASE      = 8'h40;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLDOFF_CYCLES = 150;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         MAX_REPORTS    = 10;

  logic clk;
  logic rst_n;

  cnw_in_if  in_if ();
  cnw_out_if out_if ();
  cnw_cfg_if cfg_if ();

  char_lcd_nibble_writer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // --------------------------------------------------------------------------
  // line model state: timing registers plus the sequencer of the block
  // --------------------------------------------------------------------------
  logic [7:0]  pulse_ticks;
  logic [15:0] short_wait;
  logic [15:0] long_wait;

  logic [3:0]  seq_phase;
  logic [7:0]  seq_byte;
  logic        seq_rs;
  logic        seq_long;
  logic [15:0] seq_count;

  cnw_pkg::cnw_item_t   lcd_items[$];    // items waiting to be offered
  cnw_pkg::cnw_result_t line_levels[$];  // line levels owed by the block, oldest first
  cnw_pkg::cnw_item_t   offered;         // item currently on the input channel

  int          mismatch_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          holdoff_req;
  int          holdoff_done;
  int          holdoff_left;
  int          quiet_cycles;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // line model
  // --------------------------------------------------------------------------

  // counts one tick of a timed phase, true once the limit is reached;
  // a zero limit ends after one tick like a limit of one
  function automatic bit tick_done(input logic [15:0] limit);
    seq_count = seq_count + 16'd1;
    return seq_count >= limit;
  endfunction

  // one microsecond tick through the sequencer
  function automatic void seq_tick();
    logic [15:0] wait_len;
    case (seq_phase)
      PH_SETUP_HI: begin
        seq_phase = PH_PULSE_HI;
        seq_count = '0;
      end
      PH_PULSE_HI: begin
        if (tick_done({8'd0, pulse_ticks})) begin
          seq_phase = PH_GAP;
          seq_count = '0;
        end
      end
      PH_GAP: seq_phase = PH_SETUP_LO;
      PH_SETUP_LO: begin
        seq_phase = PH_PULSE_LO;
        seq_count = '0;
      end
      PH_PULSE_LO: begin
        if (tick_done({8'd0, pulse_ticks})) begin
          seq_phase = PH_WAIT;
          seq_count = '0;
        end
      end
      PH_WAIT: begin
        wait_len = seq_long ? long_wait : short_wait;
        if (tick_done(wait_len)) begin
          seq_phase = PH_IDLE;
          seq_count = '0;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
  endfunction

  // works out the line levels after one accepted item and queues them
  function automatic void predict_lines(input cnw_pkg::cnw_item_t it);
    cnw_pkg::cnw_result_t lv;
    lv = '0;
    if (it.func == cnw_pkg::FUNC_TICK) begin
      if (seq_phase != PH_IDLE) seq_tick();
    end else if (seq_phase == PH_IDLE) begin
      // writes are only taken while idle, refused ones change nothing
      lv.accepted = 1'b1;
      if (it.func == cnw_pkg::FUNC_CURSOR) begin
        // set-address command; columns past the line end pass through
        seq_byte = SET_ADDR_CMD | ({2'b00, it.column} + (it.row ? ROW1_BASE : 8'h00));
        seq_rs   = 1'b0;
        seq_long = 1'b0;
      end else begin
        seq_byte = it.value;
        seq_rs   = (it.func == cnw_pkg::FUNC_CHAR);
        // only clear and home commands take the long wait
        seq_long = (it.func == cnw_pkg::FUNC_CMD) &&
                   (it.value == cnw_pkg::CMD_CLEAR || it.value == cnw_pkg::CMD_HOME);
      end
      seq_count = '0;
      seq_phase = PH_SETUP_HI;
    end
    case (seq_phase)
      PH_SETUP_HI: begin
        lv.data_nibble = seq_byte[7:4];
        lv.rs_line     = seq_rs;
      end
      PH_PULSE_HI: begin
        lv.data_nibble = seq_byte[7:4];
        lv.rs_line     = seq_rs;
        lv.en_line     = 1'b1;
      end
      PH_SETUP_LO: begin
        lv.data_nibble = seq_byte[3:0];
        lv.rs_line     = seq_rs;
      end
      PH_PULSE_LO: begin
        lv.data_nibble = seq_byte[3:0];
        lv.rs_line     = seq_rs;
        lv.en_line     = 1'b1;
      end
      default: ;
    endcase
    lv.busy_res = (seq_phase != PH_IDLE);
    line_levels.push_back(lv);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // ticks from a taken write back to idle under the current timing setup
  function automatic int ticks_for_byte(input bit long_flag);
    int p;
    int w;
    p = (pulse_ticks == 0) ? 1 : int'(pulse_ticks);
    w = long_flag ? int'(long_wait) : int'(short_wait);
    if (w == 0) w = 1;
    return 3 + 2 * p + w;
  endfunction

  function automatic cnw_pkg::cnw_item_t rand_tick();
    cnw_pkg::cnw_item_t it;
    it.func   = cnw_pkg::FUNC_TICK;
    it.value  = 8'($urandom_range(255));
    it.column = 6'($urandom_range(63));
    it.row    = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic cnw_pkg::cnw_item_t rand_write();
    cnw_pkg::cnw_item_t it;
    int                 pick;
    it      = rand_tick();
    it.func = 2'($urandom_range(cnw_pkg::FUNC_CURSOR, cnw_pkg::FUNC_CMD));
    pick    = $urandom_range(99);
    // lean on clear and home so the long wait shows up often
    if (pick < 15) it.value = cnw_pkg::CMD_CLEAR;
    else if (pick < 25) it.value = cnw_pkg::CMD_HOME;
    // columns past the visible line now and then
    it.column = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 40)) : 6'($urandom_range(39));
    return it;
  endfunction

  function automatic bit takes_long_wait(input cnw_pkg::cnw_item_t it);
    return (it.func == cnw_pkg::FUNC_CMD) &&
           (it.value == cnw_pkg::CMD_CLEAR || it.value == cnw_pkg::CMD_HOME);
  endfunction

  task automatic push_item(input logic [1:0] f, input logic [7:0] v,
                           input logic [5:0] col, input logic r);
    cnw_pkg::cnw_item_t it;
    it.func   = f;
    it.value  = v;
    it.column = col;
    it.row    = r;
    lcd_items.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) lcd_items.push_back(rand_tick());
  endtask

  // mostly well-formed traffic: a write and the ticks it needs, with
  // refused writes sprinkled in, some bytes cut short and some overrun
  task automatic queue_lcd_traffic(input int n);
    int                 queued;
    int                 ticks;
    int                 roll;
    cnw_pkg::cnw_item_t w;
    queued = 0;
    while (queued < n) begin
      w = rand_write();
      lcd_items.push_back(w);
      queued++;
      ticks = ticks_for_byte(takes_long_wait(w));
      roll  = $urandom_range(99);
      if (roll < 10) ticks = $urandom_range(ticks - 1);
      else if (roll < 20) ticks += $urandom_range(4, 1);
      repeat (ticks) begin
        if ($urandom_range(9) == 0) lcd_items.push_back(rand_write());
        lcd_items.push_back(rand_tick());
        queued++;
      end
    end
  endtask

  // one register write transfer, model copy updated at the handshake
  task automatic write_reg(input logic [cnw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cnw_pkg::CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      cnw_pkg::REG_PULSE:      pulse_ticks = val[7:0];
      cnw_pkg::REG_SHORT_WAIT: short_wait  = val;
      cnw_pkg::REG_LONG_WAIT:  long_wait   = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [15:0] pulse, input logic [15:0] s_wait,
                                input logic [15:0] l_wait);
    write_reg(cnw_pkg::REG_PULSE, pulse);
    write_reg(cnw_pkg::REG_SHORT_WAIT, s_wait);
    write_reg(cnw_pkg::REG_LONG_WAIT, l_wait);
    cfg_if.valid <= 1'b0;
  endtask

  // sender holds back until every owed result has come out
  task automatic wait_lcd_idle();
    while (lcd_items.size() != 0 || in_if.valid || line_levels.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // input driver: offers queued items, holding each until its transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_lines(offered);
      if (!in_if.valid || in_if.ready) begin
        if (lcd_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = lcd_items.pop_front();
          in_if.valid  <= 1'b1;
          in_if.func   <= offered.func;
          in_if.value  <= offered.value;
          in_if.column <= offered.column;
          in_if.row    <= offered.row;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold-off on request so the
  // block backs up and drops its input ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      out_if.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req != holdoff_done) begin
      out_if.ready <= 1'b0;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= holdoff_done + 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each result transfer against the oldest owed levels
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cnw_pkg::cnw_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (line_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with nothing owed: nib=%h rs=%b en=%b busy=%b acc=%b",
                   $realtime, out_if.data_nibble, out_if.rs_line, out_if.en_line,
                   out_if.busy_res, out_if.accepted);
      end else begin
        want = line_levels.pop_front();
        if (out_if.data_nibble !== want.data_nibble || out_if.rs_line !== want.rs_line ||
            out_if.en_line !== want.en_line || out_if.busy_res !== want.busy_res ||
            out_if.accepted !== want.accepted) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t: lines differ: want nib=%h rs=%b en=%b busy=%b acc=%b",
                   $realtime, want.data_nibble, want.rs_line, want.en_line,
                   want.busy_res, want.accepted);
            $display(", got nib=%h rs=%b en=%b busy=%b acc=%b",
                     out_if.data_nibble, out_if.rs_line, out_if.en_line,
                     out_if.busy_res, out_if.accepted);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: a stretch without a transfer on any channel that reaches the limit ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = cnw_pkg::FUNC_TICK;
    in_if.value    = '0;
    in_if.column   = '0;
    in_if.row      = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = cnw_pkg::REG_PULSE;
    cfg_if.data    = '0;
    mismatch_count = 0;
    holdoff_req    = 0;
    holdoff_done   = 0;
    quiet_cycles   = 0;
    tx_idle_pct    = 16;
    rx_idle_pct    = 77;

    // model matches the block's reset state
    pulse_ticks = cnw_pkg::PULSE_RST;
    short_wait  = cnw_pkg::SHORT_WAIT_RST;
    long_wait   = cnw_pkg::LONG_WAIT_RST;
    seq_phase   = PH_IDLE;
    seq_byte    = '0;
    seq_rs      = 1'b0;
    seq_long    = 1'b0;
    seq_count   = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short timing so a full byte is a handful of ticks
    program_timing(16'd1, 16'd1, 16'd2);
    // tick while idle leaves everything low
    push_ticks(1);
    // clear takes the long wait; a character offered while busy is refused
    push_item(cnw_pkg::FUNC_CMD, cnw_pkg::CMD_CLEAR, 6'd0, 1'b0);
    push_item(cnw_pkg::FUNC_CHAR, 8'hFF, 6'd63, 1'b1);
    push_ticks(ticks_for_byte(1'b1));
    // cursor move at the widest column on row one gives address 0x7F, command byte 0xFF
    push_item(cnw_pkg::FUNC_CURSOR, 8'h01, 6'd63, 1'b1);
    push_ticks(ticks_for_byte(1'b0));
    // home takes the long wait, a cursor move during it is refused
    push_item(cnw_pkg::FUNC_CMD, cnw_pkg::CMD_HOME, 6'd0, 1'b0);
    push_item(cnw_pkg::FUNC_CURSOR, 8'h00, 6'd0, 1'b0);
    push_ticks(ticks_for_byte(1'b1));
    // character 0x02 is data, so it takes the short wait
    push_item(cnw_pkg::FUNC_CHAR, cnw_pkg::CMD_HOME, 6'd0, 1'b0);
    push_ticks(ticks_for_byte(1'b0));
    wait_lcd_idle();

    // sender idles lightly, receiver heavily
    program_timing(16'd3, 16'd5, 16'd9);
    queue_lcd_traffic(90);
    wait_lcd_idle();

    // roles swapped; zero lengths, the pulse written with only upper data bits, which are dropped
    tx_idle_pct = 77;
    rx_idle_pct = 16;
    program_timing(16'h0100, 16'd0, 16'd0);
    queue_lcd_traffic(90);
    wait_lcd_idle();

    // no idling; receiver holds off once so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_timing(16'd2, 16'd4, 16'd6);
    queue_lcd_traffic(90);
    holdoff_req++;
    wait_lcd_idle();

    // widest pulse with the longest long wait; the clear runs through its
    // whole high pulse into the low one, a character behind it is refused
    program_timing(16'hFFFF, 16'd1, 16'hFFFF);
    push_item(cnw_pkg::FUNC_CMD, cnw_pkg::CMD_CLEAR, 6'd0, 1'b0);
    push_ticks(260);
    push_item(cnw_pkg::FUNC_CHAR, 8'h5A, 6'd0, 1'b0);
    wait_lcd_idle();

    // longest short wait, shortest long wait: the clear finishes at once,
    // a cursor move then sits in its wait and a home behind it is refused
    program_timing(16'd1, 16'hFFFF, 16'd1);
    push_ticks(2);
    push_item(cnw_pkg::FUNC_CURSOR, 8'h00, 6'd39, 1'b0);
    push_ticks(20);
    push_item(cnw_pkg::FUNC_CMD, cnw_pkg::CMD_HOME, 6'd0, 1'b0);
    wait_lcd_idle();

    // let the pipeline settle before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_levels.size() != 0) begin
      $display("%0d results never came out", line_levels.size());
      mismatch_count += line_levels.size();
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cnw_pkg.sv
rtl/cnw_ifs.sv
rtl/cnw_cfg_regs.sv
rtl/cnw_seq.sv
rtl/char_lcd_nibble_writer.sv
rtl/cnw_checker.sv
tb/char_lcd_nibble_writer_tb.sv
